// ===== hdl/spba_pkg.sv =====
// ----------------------------------------------------------------------------
// spba_pkg: shared types and constants of the segregated pool allocator
// Transaction structs, status and action codes, register indexes and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package spba_pkg;

  localparam int POOLS     = 3;
  localparam int POOL_W    = 2;
  localparam int OFFSET_W  = 10;
  localparam int REQ_W     = 16;
  localparam int BYTES_W   = 10;
  localparam int COUNT_W   = 4;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  localparam int DEF_MAX_BLOCKS_PER_POOL = 8;

  // Status codes of a result transaction.
  localparam logic [STATUS_W-1:0] ST_ALLOCATED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL_IGNORE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BEYOND      = 3'd4;

  // Action codes of a request transaction.
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POOL0_BYTES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL1_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL2_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL0_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POOL1_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POOL2_COUNT = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [BYTES_W-1:0] RST_POOL0_BYTES = 10'd32;
  localparam logic [BYTES_W-1:0] RST_POOL1_BYTES = 10'd96;
  localparam logic [BYTES_W-1:0] RST_POOL2_BYTES = 10'd192;
  localparam logic [COUNT_W-1:0] RST_POOL0_COUNT = 4'd1;
  localparam logic [COUNT_W-1:0] RST_POOL1_COUNT = 4'd4;
  localparam logic [COUNT_W-1:0] RST_POOL2_COUNT = 4'd1;

  typedef struct packed {
    logic                action;
    logic [REQ_W-1:0]    request_bytes;
    logic [OFFSET_W-1:0] release_offset;
    logic                release_is_null;
  } spba_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] block_offset;
    logic [POOL_W-1:0]   pool_index;
  } spba_out_t;

endpackage

// ===== hdl/segregated_pool_block_allocator.sv =====
// ----------------------------------------------------------------------------
// segregated_pool_block_allocator: three-pool fixed-block heap allocator
// Hands out and takes back fixed-size blocks of three pools that sit back to
// back in a byte-addressed heap, each pool keeping a LIFO free stack.
// ----------------------------------------------------------------------------
// Usage
//   A request transaction on the in_ channel either allocates a block of at
//   least request_bytes from the first pool that fits and still has a free
//   block, or releases the block at release_offset back to the pool whose
//   address range holds it. Every request yields exactly one result
//   transaction on the out_ channel with a status, the block offset and the
//   pool index. Pool sizes and counts are to be set through the cfg_ write
//   port only while the block is idle; the block does not enforce this.
//   Sizes take effect at once; the first allocation after reset fixes the
//   layout, which stays until the next reset.
// Request flow
//   A request passes the execute state, where a single stack memory access
//   (pop read or push write) is made, and the emit state that loads the
//   output register. A new request is taken in the emit state of the one
//   before it while the receiver keeps up. The first allocation after reset
//   first walks the layout with one shared adder, one block per cycle, and
//   closes each pool by latching its end offset and filling its depth.
// Reset and stalls
//   rst_n is synchronous and active low; it empties all stacks and forgets
//   the layout. When out_ready is low, the result waits in the output
//   register; the next request is still accepted and executed, and it waits
//   in the emit state until the output register frees up.
// ----------------------------------------------------------------------------
module segregated_pool_block_allocator #(
  parameter int MAX_BLOCKS_PER_POOL = spba_pkg::DEF_MAX_BLOCKS_PER_POOL
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  spba_pkg::spba_in_t              in_data,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output spba_pkg::spba_out_t             out_data,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [spba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Stack memory holds MAX_BLOCKS_PER_POOL entries per pool. Pool end
  // offsets are kept at full precision: they never reach 3 * MAX * 1024.
  localparam int DEPTH = spba_pkg::POOLS * MAX_BLOCKS_PER_POOL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = $clog2(MAX_BLOCKS_PER_POOL + 1);
  localparam int EW    = AW + spba_pkg::OFFSET_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUILD,
    S_EXEC,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [spba_pkg::BYTES_W-1:0] bytes_r [spba_pkg::POOLS];
  logic [spba_pkg::BYTES_W-1:0] bytes_nxt [spba_pkg::POOLS];
  logic [spba_pkg::COUNT_W-1:0] count_r [spba_pkg::POOLS];
  logic [spba_pkg::COUNT_W-1:0] count_nxt [spba_pkg::POOLS];

  // Allocator state.
  logic [DW-1:0] depth_r [spba_pkg::POOLS];
  logic [DW-1:0] depth_nxt [spba_pkg::POOLS];
  logic [EW-1:0] end_r [spba_pkg::POOLS];
  logic [EW-1:0] end_nxt [spba_pkg::POOLS];
  logic          built_r, built_nxt;

  // Layout walk: pool, block within the pool and running heap address.
  logic [spba_pkg::POOL_W-1:0] bpool_r, bpool_nxt;
  logic [DW-1:0]               bk_r, bk_nxt;
  logic [EW-1:0]               addr_r, addr_nxt;

  // Request held during its execution, and the result awaiting emission.
  spba_pkg::spba_in_t          item_r, item_nxt;
  logic [spba_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [spba_pkg::POOL_W-1:0]   res_pool_r, res_pool_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  spba_pkg::spba_out_t   out_data_r, out_data_nxt;

  // Stack memory ports.
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [spba_pkg::OFFSET_W-1:0] ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [spba_pkg::OFFSET_W-1:0] ram_rdata;

  // Pool selection for the request in execution.
  logic [spba_pkg::POOLS-1:0]  alloc_match;
  logic [spba_pkg::POOLS-1:0]  rel_match;
  logic [spba_pkg::POOLS-1:0]  match;
  logic                        sel_hit;
  logic [spba_pkg::POOL_W-1:0] sel_pool;
  logic [DW-1:0]               sel_depth;
  logic [DW-1:0]               bcount;
  logic                        in_fire;
  logic                        out_free;

  // Memory address of entry i of pool p's stack.
  function automatic logic [AW-1:0] stack_addr(logic [spba_pkg::POOL_W-1:0] p,
                                               logic [DW-1:0] i);
    return AW'(p) * AW'(MAX_BLOCKS_PER_POOL) + AW'(i);
  endfunction

  // Block count of a pool, limited to the stack capacity.
  function automatic logic [DW-1:0] capped_count(logic [spba_pkg::COUNT_W-1:0] c);
    if (32'(c) > 32'(MAX_BLOCKS_PER_POOL)) begin
      return DW'(MAX_BLOCKS_PER_POOL);
    end
    return DW'(c);
  endfunction

  spba_stack_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_EMIT) && out_free);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Both searches compare all three pools at once and take the lowest match.
  always_comb begin
    for (int p = 0; p < spba_pkg::POOLS; p++) begin
      alloc_match[p] = (spba_pkg::REQ_W'(bytes_r[p]) >= item_r.request_bytes) &&
                       (depth_r[p] != '0);
      rel_match[p]   = EW'(item_r.release_offset) < end_r[p];
    end
    match    = (item_r.action == spba_pkg::ACT_ALLOC) ? alloc_match : rel_match;
    sel_hit  = 1'b0;
    sel_pool = '0;
    for (int p = spba_pkg::POOLS - 1; p >= 0; p--) begin
      if (match[p]) begin
        sel_hit  = 1'b1;
        sel_pool = spba_pkg::POOL_W'(p);
      end
    end
    sel_depth = depth_r[sel_pool];
    bcount    = capped_count(count_r[bpool_r]);
  end

  always_comb begin
    state_nxt      = state_r;
    bytes_nxt      = bytes_r;
    count_nxt      = count_r;
    depth_nxt      = depth_r;
    end_nxt        = end_r;
    built_nxt      = built_r;
    bpool_nxt      = bpool_r;
    bk_nxt         = bk_r;
    addr_nxt       = addr_r;
    item_nxt       = item_r;
    res_status_nxt = res_status_r;
    res_pool_nxt   = res_pool_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = stack_addr(sel_pool, sel_depth);
    ram_wdata      = item_r.release_offset;
    ram_re         = 1'b0;
    ram_raddr      = stack_addr(sel_pool, sel_depth - DW'(1));

    if (cfg_we) begin
      case (cfg_index)
        spba_pkg::REG_POOL0_BYTES: bytes_nxt[0] = cfg_wdata;
        spba_pkg::REG_POOL1_BYTES: bytes_nxt[1] = cfg_wdata;
        spba_pkg::REG_POOL2_BYTES: bytes_nxt[2] = cfg_wdata;
        spba_pkg::REG_POOL0_COUNT: count_nxt[0] = cfg_wdata[spba_pkg::COUNT_W-1:0];
        spba_pkg::REG_POOL1_COUNT: count_nxt[1] = cfg_wdata[spba_pkg::COUNT_W-1:0];
        spba_pkg::REG_POOL2_COUNT: count_nxt[2] = cfg_wdata[spba_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: ;

      // One block per cycle through the shared adder; a closing step per pool
      // latches its end offset and fills its depth.
      S_BUILD: begin
        if (bk_r < bcount) begin
          ram_we    = 1'b1;
          ram_waddr = stack_addr(bpool_r, bk_r);
          ram_wdata = addr_r[spba_pkg::OFFSET_W-1:0];
          addr_nxt  = addr_r + EW'(bytes_r[bpool_r]);
          bk_nxt    = bk_r + DW'(1);
        end else begin
          end_nxt[bpool_r]   = addr_r;
          depth_nxt[bpool_r] = bcount;
          bk_nxt             = '0;
          if (bpool_r == spba_pkg::POOL_W'(spba_pkg::POOLS - 1)) begin
            built_nxt = 1'b1;
            state_nxt = S_EXEC;
          end else begin
            bpool_nxt = bpool_r + spba_pkg::POOL_W'(1);
          end
        end
      end

      S_EXEC: begin
        res_pool_nxt = '0;
        state_nxt    = S_EMIT;
        if (item_r.action == spba_pkg::ACT_ALLOC) begin
          if (sel_hit) begin
            ram_re              = 1'b1;
            depth_nxt[sel_pool] = sel_depth - DW'(1);
            res_status_nxt      = spba_pkg::ST_ALLOCATED;
            res_pool_nxt        = sel_pool;
          end else begin
            res_status_nxt = spba_pkg::ST_ALLOC_FAIL;
          end
        end else if (item_r.release_is_null) begin
          res_status_nxt = spba_pkg::ST_NULL_IGNORE;
        end else if (sel_hit) begin
          // A push onto a full stack is dropped; the release still reports.
          if (sel_depth < DW'(MAX_BLOCKS_PER_POOL)) begin
            ram_we              = 1'b1;
            depth_nxt[sel_pool] = sel_depth + DW'(1);
          end
          res_status_nxt = spba_pkg::ST_RELEASED;
          res_pool_nxt   = sel_pool;
        end else begin
          res_status_nxt = spba_pkg::ST_BEYOND;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = res_status_r;
          out_data_nxt.pool_index = res_pool_r;
          out_data_nxt.block_offset = (res_status_r == spba_pkg::ST_ALLOCATED) ?
                                      ram_rdata : '0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // A new request may enter from idle or from an emit that completes.
    if (in_fire) begin
      item_nxt = in_data;
      if ((in_data.action == spba_pkg::ACT_ALLOC) && !built_r) begin
        state_nxt = S_BUILD;
        bpool_nxt = '0;
        bk_nxt    = '0;
        addr_nxt  = '0;
      end else begin
        state_nxt = S_EXEC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bytes_r[0]  <= spba_pkg::RST_POOL0_BYTES;
      bytes_r[1]  <= spba_pkg::RST_POOL1_BYTES;
      bytes_r[2]  <= spba_pkg::RST_POOL2_BYTES;
      count_r[0]  <= spba_pkg::RST_POOL0_COUNT;
      count_r[1]  <= spba_pkg::RST_POOL1_COUNT;
      count_r[2]  <= spba_pkg::RST_POOL2_COUNT;
      for (int p = 0; p < spba_pkg::POOLS; p++) begin
        depth_r[p] <= '0;
        end_r[p]   <= '0;
      end
      built_r     <= 1'b0;
      bpool_r     <= '0;
      bk_r        <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bytes_r     <= bytes_nxt;
      count_r     <= count_nxt;
      depth_r     <= depth_nxt;
      end_r       <= end_nxt;
      built_r     <= built_nxt;
      bpool_r     <= bpool_nxt;
      bk_r        <= bk_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r       <= item_nxt;
    res_status_r <= res_status_nxt;
    res_pool_r   <= res_pool_nxt;
    out_data_r   <= out_data_nxt;
  end

  // No stack ever holds more entries than its capacity.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r[0] <= DW'(MAX_BLOCKS_PER_POOL)) &&
    (depth_r[1] <= DW'(MAX_BLOCKS_PER_POOL)) &&
    (depth_r[2] <= DW'(MAX_BLOCKS_PER_POOL)))
    else $error("free stack depth above capacity");

  // An accepted request always starts execution or the layout walk.
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> ((state_r == S_EXEC) || (state_r == S_BUILD)))
    else $error("accepted request did not start");

  // An allocation never executes on an unbuilt layout.
  a_alloc_built: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && (item_r.action == spba_pkg::ACT_ALLOC)) |-> built_r)
    else $error("allocation executed before the pools were built");

  // A successful allocation pops exactly one entry from the chosen pool.
  a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && (item_r.action == spba_pkg::ACT_ALLOC) && sel_hit) |=>
    ((depth_r[$past(sel_pool)] + DW'(1)) == $past(sel_depth)))
    else $error("allocation did not pop the chosen stack");

  // A result only appears out of the emit state.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside the emit state");

endmodule

// ===== hdl/spba_stack_ram.sv =====
// ----------------------------------------------------------------------------
// spba_stack_ram: free-stack storage of all pools
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spba_stack_ram #(
  parameter int DEPTH = 3 * spba_pkg::DEF_MAX_BLOCKS_PER_POOL,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [spba_pkg::OFFSET_W-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [spba_pkg::OFFSET_W-1:0] rdata
);

  logic [spba_pkg::OFFSET_W-1:0] mem [DEPTH];
  logic [spba_pkg::OFFSET_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== test/segregated_pool_block_allocator_test.sv =====
// ----------------------------------------------------------------------------
// segregated_pool_block_allocator_test: self-checking bench for the allocator
// Drives allocate and release transactions with random gaps and result-side
// stalls. A behavioral copy of the three free stacks predicts every result,
// and the results are checked field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module segregated_pool_block_allocator_test;

  localparam int MAX_BLOCKS     = spba_pkg::DEF_MAX_BLOCKS_PER_POOL;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 128;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 300;
  // The first allocation walks the whole layout before it is served, so the
  // settle pause covers that walk plus the request's execute and emit states.
  localparam int SETTLE_CYCLES  = 3 * (MAX_BLOCKS + 1) + 4;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int REPORT_LINES   = 100;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  spba_pkg::spba_in_t   in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  spba_pkg::spba_out_t  out_data;
  logic                            cfg_we = 1'b0;
  logic [spba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [spba_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  segregated_pool_block_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow allocator. It holds its own copy of the registers, the free stacks
  // and the latched pool ends, and it is advanced once per accepted request.
  // The registers only change while the block is idle, so updating the copy
  // at the moment of the write keeps it in step with the hardware.
  // --------------------------------------------------------------------------
  logic [spba_pkg::BYTES_W-1:0]  pool_bytes [spba_pkg::POOLS] =
    '{spba_pkg::RST_POOL0_BYTES, spba_pkg::RST_POOL1_BYTES, spba_pkg::RST_POOL2_BYTES};
  logic [spba_pkg::COUNT_W-1:0]  pool_count [spba_pkg::POOLS] =
    '{spba_pkg::RST_POOL0_COUNT, spba_pkg::RST_POOL1_COUNT, spba_pkg::RST_POOL2_COUNT};
  logic [spba_pkg::OFFSET_W-1:0] free_stack [spba_pkg::POOLS][MAX_BLOCKS];
  int unsigned                   stack_depth [spba_pkg::POOLS] = '{0, 0, 0};
  // Pool ends are kept at full precision; block offsets wrap at 1024 while
  // the ends do not, so a layout past the heap can never report "beyond".
  int unsigned                   pool_limit [spba_pkg::POOLS] = '{0, 0, 0};
  bit                            layout_built = 1'b0;

  function automatic spba_pkg::spba_out_t serve_request(spba_pkg::spba_in_t req);
    spba_pkg::spba_out_t res;
    int unsigned         addr;
    int unsigned         n;
    bit                  done;
    res.status       = spba_pkg::ST_ALLOC_FAIL;
    res.block_offset = '0;
    res.pool_index   = '0;
    done             = 1'b0;
    if (req.action == spba_pkg::ACT_ALLOC) begin
      // The first allocation lays the pools out back to back and fills each
      // stack in address order, so the highest block sits on top.
      if (!layout_built) begin
        addr = 0;
        for (int p = 0; p < spba_pkg::POOLS; p++) begin
          n = (pool_count[p] > MAX_BLOCKS) ? MAX_BLOCKS : pool_count[p];
          for (int k = 0; k < n; k++) begin
            free_stack[p][k] = addr[spba_pkg::OFFSET_W-1:0];
            addr = addr + pool_bytes[p];
          end
          stack_depth[p] = n;
          pool_limit[p]  = addr;
        end
        layout_built = 1'b1;
      end
      // Sizes are matched against the live registers, not the latched layout.
      for (int p = 0; p < spba_pkg::POOLS && !done; p++) begin
        if (req.request_bytes <= pool_bytes[p] && stack_depth[p] != 0) begin
          stack_depth[p]   = stack_depth[p] - 1;
          res.block_offset = free_stack[p][stack_depth[p]];
          res.status       = spba_pkg::ST_ALLOCATED;
          res.pool_index   = spba_pkg::POOL_W'(p);
          done             = 1'b1;
        end
      end
    end else if (req.release_is_null) begin
      res.status = spba_pkg::ST_NULL_IGNORE;
    end else begin
      // Before the layout exists all ends are zero and nothing matches.
      res.status = spba_pkg::ST_BEYOND;
      for (int p = 0; p < spba_pkg::POOLS && !done; p++) begin
        if (req.release_offset < pool_limit[p]) begin
          // A push onto a full stack is dropped, yet it still counts as released.
          if (stack_depth[p] < MAX_BLOCKS) begin
            free_stack[p][stack_depth[p]] = req.release_offset;
            stack_depth[p] = stack_depth[p] + 1;
          end
          res.status     = spba_pkg::ST_RELEASED;
          res.pool_index = spba_pkg::POOL_W'(p);
          done           = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Bookkeeping shared by the stimulus, the driver and the monitor.
  // --------------------------------------------------------------------------
  spba_pkg::spba_in_t  request_queue [$];
  spba_pkg::spba_out_t expected_results [$];
  int        queued_count = 0;
  int        accepted_count = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        idle_level = 0;
  int        hold_ask = 0;
  int        hold_seen = 0;
  int        tx_wait = 0;
  int        rx_wait = 0;
  logic      in_fire = 1'b0;
  logic      out_fire = 1'b0;

  // Idle level 0 gives back-to-back traffic, 1 an occasional gap, and 2 a
  // random gap after every transaction.
  function automatic int draw_gap();
    case (idle_level)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < REPORT_LINES)
      $display("cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver. Inputs change on the falling edge. A request stays on the bus
  // until it is taken; after each accepted transaction the sender draws a
  // gap before it offers the next one.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else if (!in_valid || in_fire) begin
      if (tx_wait > 0) begin
        tx_wait = tx_wait - 1;
        in_valid <= 1'b0;
      end else if (request_queue.size() != 0) begin
        in_data  <= request_queue.pop_front();
        in_valid <= 1'b1;
        tx_wait = draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. After each result it draws a stall, and on request it holds
  // out_ready low for a long stretch so the output register and the emit
  // stage fill and the block has to push back on its request channel.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      rx_wait = HOLD_CYCLES;
    end else if (out_fire) begin
      rx_wait = draw_gap();
    end
    out_ready <= (rx_wait == 0);
    if (rx_wait > 0)
      rx_wait = rx_wait - 1;
  end

  // --------------------------------------------------------------------------
  // Monitor. Both channels are sampled on the rising edge. A result is checked
  // before the request taken on the same edge is predicted, since a result
  // can never belong to a request accepted in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    spba_pkg::spba_out_t want;
    in_fire  <= rst_n && in_valid && in_ready;
    out_fire <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending", out_data.status, -1);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.block_offset !== want.block_offset)
            report_mismatch("block_offset", out_data.block_offset, want.block_offset);
          if (out_data.pool_index !== want.pool_index)
            report_mismatch("pool_index", out_data.pool_index, want.pool_index);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(serve_request(in_data));
        accepted_count++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Fields that the operation ignores are still random so
  // every bit of every field toggles.
  // --------------------------------------------------------------------------
  task automatic push_alloc(int bytes);
    spba_pkg::spba_in_t it;
    it.action          = spba_pkg::ACT_ALLOC;
    it.request_bytes   = spba_pkg::REQ_W'(bytes);
    it.release_offset  = spba_pkg::OFFSET_W'($urandom);
    it.release_is_null = 1'($urandom);
    request_queue.push_back(it);
    queued_count++;
  endtask

  task automatic push_release(int offset, bit is_null);
    spba_pkg::spba_in_t it;
    it.action          = spba_pkg::ACT_RELEASE;
    it.request_bytes   = spba_pkg::REQ_W'($urandom);
    it.release_offset  = spba_pkg::OFFSET_W'(offset);
    it.release_is_null = is_null;
    request_queue.push_back(it);
    queued_count++;
  endtask

  // Returns on a falling edge once every request has been taken and answered
  // and the block has had time to finish any internal work.
  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_count != queued_count || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Called on a falling edge; the enable stays high across back-to-back
  // writes and drops after the last one.
  task automatic write_reg(logic [spba_pkg::CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= spba_pkg::CFG_DATA_W'(value);
    if (idx <= spba_pkg::REG_POOL2_BYTES)
      pool_bytes[idx - spba_pkg::REG_POOL0_BYTES] = spba_pkg::BYTES_W'(value);
    else
      pool_count[idx - spba_pkg::REG_POOL0_COUNT] = spba_pkg::COUNT_W'(value);
    @(negedge clk);
  endtask

  task automatic program_pools(int b0, int b1, int b2, int c0, int c1, int c2);
    write_reg(spba_pkg::REG_POOL0_BYTES, b0);
    write_reg(spba_pkg::REG_POOL1_BYTES, b1);
    write_reg(spba_pkg::REG_POOL2_BYTES, b2);
    write_reg(spba_pkg::REG_POOL0_COUNT, c0);
    write_reg(spba_pkg::REG_POOL1_COUNT, c1);
    write_reg(spba_pkg::REG_POOL2_COUNT, c2);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence. Reset is applied once, so the layout latched by the first
  // allocation holds for the whole run. It is chosen to hit three corners at
  // once: pool 0 asks for more blocks than a stack holds, pool 1 runs past the
  // end of the heap so its last block wraps into pool 0's range, and pool 2
  // has no blocks at all. Later phases only move the block sizes (and rewrite
  // the counts, which no longer matter) while the stacks keep their contents.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned addr;
    int          n;
    int          block_list [$];
    int          alloc_pct;
    int          p;
    int          bytes;
    int          pick;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Releases before any allocation: no pool ends exist yet.
    push_release(0, 1'b0);
    push_release(1023, 1'b1);
    push_release(1023, 1'b0);
    wait_drained();

    program_pools(40, 110, 1023, 9, 8, 0);

    // Every block address of the layout, as the first allocation builds it.
    addr = 0;
    for (int q = 0; q < spba_pkg::POOLS; q++) begin
      n = (pool_count[q] > MAX_BLOCKS) ? MAX_BLOCKS : pool_count[q];
      for (int k = 0; k < n; k++) begin
        block_list.push_back(addr % 1024);
        addr = addr + pool_bytes[q];
      end
    end
    @(posedge clk);

    // Directed: build, size matching at the pool boundaries, oversize and
    // empty-pool failures, releases around the pool ends and the wrapped
    // block, null releases, a push onto a full stack, then draining pool 0
    // so a small request spills over into pool 1.
    push_alloc(0);
    push_alloc(65535);
    push_alloc(40);
    push_alloc(41);
    push_alloc(110);
    push_alloc(111);
    push_alloc(1023);
    push_release(1023, 1'b0);
    push_release(96, 1'b0);
    push_release(319, 1'b0);
    push_release(320, 1'b0);
    push_release(66, 1'b0);
    push_release(1023, 1'b1);
    push_release(0, 1'b1);
    repeat (9) push_alloc(1);
    wait_drained();

    // Random phases, each with its own sizes, operation mix and idle level.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       program_pools(40, 100, 1023, 9, 8, 0);
        1:       program_pools(8, 1023, 8, 0, 0, 0);
        2:       program_pools(1023, 8, 1023, 8, 8, 8);
        3:       program_pools(1023, 1023, 1023, 15, 1, 2);
        4:       program_pools(8, 8, 8, 3, 0, 8);
        default: program_pools($urandom_range(8, 1023), $urandom_range(8, 1023),
                               $urandom_range(8, 1023), $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(0, 15));
      endcase
      @(posedge clk);
      case (phase % 3)
        0:       alloc_pct = 55;
        1:       alloc_pct = 75;
        default: alloc_pct = 30;
      endcase
      idle_level = phase % 3;
      if (phase == PRESSURE_PHASE) begin
        idle_level = 0;
        hold_ask <= hold_ask + 1;
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          // Sizes cluster around the current block sizes so every pool is
          // tried, with an occasional request of any size.
          p = $urandom_range(0, spba_pkg::POOLS - 1);
          case ($urandom_range(0, 9))
            0, 1, 2: bytes = $urandom_range(0, pool_bytes[p]);
            3:       bytes = pool_bytes[p];
            4:       bytes = pool_bytes[p] + 1;
            5:       bytes = 0;
            6, 7:    bytes = $urandom_range(0, 65535);
            default: bytes = $urandom_range(0, 48);
          endcase
          push_alloc(bytes);
        end else begin
          // Mostly blocks of the real layout, some arbitrary offsets and
          // some null pointers.
          pick = $urandom_range(0, 9);
          if (pick < 7)
            push_release(block_list[$urandom_range(0, block_list.size() - 1)], 1'b0);
          else if (pick < 8)
            push_release($urandom_range(0, 1023), 1'b0);
          else
            push_release($urandom_range(0, 1023), 1'b1);
        end
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/spba_pkg.sv
hdl/spba_stack_ram.sv
hdl/segregated_pool_block_allocator.sv
test/segregated_pool_block_allocator_test.sv
